// File: design/cssg_pkg.sv
package cssg_pkg;

  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
  localparam int unsigned EXP_TABLE_DEPTH_DEF  = 256;

  localparam logic [31:0] Q30_ONE    = 32'h4000_0000;
  localparam logic [31:0] TWO_PI_Q29 = 32'd3373259426;

  // configuration register indexes
  localparam logic [2:0] CFG_SWEEP_MODE = 3'd0;
  localparam logic [2:0] CFG_AMPLITUDE  = 3'd1;
  localparam logic [2:0] CFG_DC_OFFSET  = 3'd2;
  localparam logic [2:0] CFG_START_FREQ = 3'd3;
  localparam logic [2:0] CFG_STOP_FREQ  = 3'd4;
  localparam logic [2:0] CFG_SWEEP_LEN  = 3'd5;

  localparam logic        SWEEP_LOG = 1'b0;
  localparam logic        SWEEP_LIN = 1'b1;

  localparam logic [30:0] START_FREQ_RST = 31'd1;
  localparam logic [30:0] STOP_FREQ_RST  = 31'd1000;
  localparam logic [31:0] SWEEP_LEN_RST  = 32'd100000;

  // Q30 roots 2^(2^-(j+1))
  function automatic logic [31:0] root_q30(input logic [3:0] j);
    logic [31:0] r;
    case (j)
      4'd0:    r = 32'd1518500250;
      4'd1:    r = 32'd1276901417;
      4'd2:    r = 32'd1170923762;
      4'd3:    r = 32'd1121280436;
      4'd4:    r = 32'd1097253708;
      4'd5:    r = 32'd1085434106;
      4'd6:    r = 32'd1079572136;
      4'd7:    r = 32'd1076653033;
      4'd8:    r = 32'd1075196438;
      4'd9:    r = 32'd1074468888;
      4'd10:   r = 32'd1074105294;
      4'd11:   r = 32'd1073923544;
      4'd12:   r = 32'd1073832680;
      4'd13:   r = 32'd1073787250;
      4'd14:   r = 32'd1073764537;
      default: r = 32'd1073753181;
    endcase
    return r;
  endfunction

  // quarter-wave odd polynomial, Q30
  function automatic logic [31:0] sin_coef(input logic [2:0] k);
    logic [31:0] c;
    case (k)
      3'd0:    c = 32'd1686629713;
      3'd1:    c = 32'd693598668;
      3'd2:    c = 32'd85569306;
      3'd3:    c = 32'd5026995;
      default: c = 32'd172272;
    endcase
    return c;
  endfunction

endpackage

// File: design/cssg_mul.sv
module cssg_mul (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [63:0] prod_o
);

  logic [63:0] prod_d;
  logic [63:0] prod_q;

  assign prod_d = a_i * b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

// File: design/chirp_sine_sweep_generator_core.sv
// No new word is taken until the result has been taken. The 64-step restoring divider
// (position and sweep fraction) and one shared registered 32x32 multiplier do the
// arithmetic.
// Reset (rst_ni low, asynchronous): phase clears, control and configuration registers take their reset values.
module chirp_sine_sweep_generator_core #(
  parameter int unsigned SINE_TABLE_DEPTH = cssg_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int unsigned EXP_TABLE_DEPTH  = cssg_pkg::EXP_TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] now_ticks_i,
  input  logic [15:0] step_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [15:0] voltage_o,
  output logic signed [31:0] slope_o,
  output logic [31:0] frequency_now_o
);

  localparam int unsigned SinAw = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned ExpAw = $clog2(EXP_TABLE_DEPTH);
  localparam logic [15:0] ExpMask = 16'hFFFF << (16 - ExpAw);

  localparam logic [4:0] ST_IDLE     = 5'd0;
  localparam logic [4:0] ST_DIV      = 5'd1;
  localparam logic [4:0] ST_LIN      = 5'd2;
  localparam logic [4:0] ST_LIN_W    = 5'd3;
  localparam logic [4:0] ST_LOG_NRM  = 5'd4;
  localparam logic [4:0] ST_LOG_SQ   = 5'd5;
  localparam logic [4:0] ST_LOG_SQ_W = 5'd6;
  localparam logic [4:0] ST_EMAG     = 5'd7;
  localparam logic [4:0] ST_EMAG_W   = 5'd8;
  localparam logic [4:0] ST_EXP      = 5'd9;
  localparam logic [4:0] ST_EXP_W    = 5'd10;
  localparam logic [4:0] ST_SCL      = 5'd11;
  localparam logic [4:0] ST_SCL_W    = 5'd12;
  localparam logic [4:0] ST_PH       = 5'd13;
  localparam logic [4:0] ST_PH_W     = 5'd14;
  localparam logic [4:0] ST_SIN_T2   = 5'd15;
  localparam logic [4:0] ST_SIN_T2_W = 5'd16;
  localparam logic [4:0] ST_SIN_H    = 5'd17;
  localparam logic [4:0] ST_SIN_H_W  = 5'd18;
  localparam logic [4:0] ST_SIN_F    = 5'd19;
  localparam logic [4:0] ST_SIN_F_W  = 5'd20;
  localparam logic [4:0] ST_VOLT     = 5'd21;
  localparam logic [4:0] ST_VOLT_W   = 5'd22;
  localparam logic [4:0] ST_SL1      = 5'd23;
  localparam logic [4:0] ST_SL1_W    = 5'd24;
  localparam logic [4:0] ST_SL2      = 5'd25;
  localparam logic [4:0] ST_SL2_W    = 5'd26;
  localparam logic [4:0] ST_SL3      = 5'd27;
  localparam logic [4:0] ST_SL3_W    = 5'd28;
  localparam logic [4:0] ST_OUT      = 5'd29;

  // configuration
  logic               mode_q;
  logic [14:0]        amp_q;
  logic signed [15:0] dc_q;
  logic [30:0]        start_q;
  logic [30:0]        stop_q;
  logic [31:0]        len_q;

  // control
  logic [4:0]  state_q, state_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        sel_q, sel_d;
  logic [31:0] phase_q, phase_d;

  // datapath
  logic [15:0]        step_q, step_d;
  logic [63:0]        dvd_q, dvd_d;
  logic [31:0]        rem_q, rem_d;
  logic [30:0]        m_q, m_d;
  logic [20:0]        lgr_q, lgr_d;
  logic [20:0]        lb_q, lb_d;
  logic [20:0]        le_q, le_d;
  logic signed [5:0]  k_q, k_d;
  logic [15:0]        qf_q, qf_d;
  logic [31:0]        acc_q, acc_d;
  logic [31:0]        f_q, f_d;
  logic [30:0]        tt_q, tt_d;
  logic [30:0]        t2s_q, t2s_d;
  logic [31:0]        p_q, p_d;
  logic               neg_q, neg_d;
  logic [14:0]        s_mag_q, s_mag_d;
  logic               s_neg_q, s_neg_d;
  logic [14:0]        c_mag_q, c_mag_d;
  logic               c_neg_q, c_neg_d;
  logic signed [15:0] volt_q, volt_d;
  logic [29:0]        ac_q, ac_d;
  logic [29:0]        st2_q, st2_d;
  logic signed [31:0] slope_q, slope_d;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  cssg_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // divider step
  logic [32:0] rem_sh;
  logic        div_ge;
  logic [32:0] rem_sub;
  assign rem_sh  = {rem_q, dvd_q[63]};
  assign div_ge  = rem_sh >= {1'b0, len_q};
  assign rem_sub = rem_sh - {1'b0, len_q};

  // linear sweep span
  logic        lin_up;
  logic [30:0] lin_span;
  assign lin_up   = stop_q >= start_q;
  assign lin_span = lin_up ? stop_q - start_q : start_q - stop_q;

  // log2 normalization
  logic [30:0] lg_x;
  logic [4:0]  lg_msb;
  assign lg_x = sel_q ? stop_q : start_q;
  always_comb begin
    lg_msb = 5'd0;
    for (int i = 0; i < 31; i++) begin
      if (lg_x[i]) lg_msb = 5'(i);
    end
  end

  logic [31:0] lg_sq;
  logic [20:0] lgr_n;
  assign lg_sq = prod[61:30];
  always_comb begin
    lgr_n = lgr_q;
    if (lg_sq[31]) lgr_n[{1'b0, cnt_q[3:0]}] = 1'b1;
  end

  logic        ex_neg;
  logic [20:0] ex_diff;
  logic [20:0] emag;
  assign ex_neg  = le_q < lb_q;
  assign ex_diff = ex_neg ? lb_q - le_q : le_q - lb_q;
  assign emag    = prod[52:32];

  logic [6:0]  scl_sh;
  logic [63:0] scl_val;
  assign scl_sh  = 7'd30 - 7'(k_q);
  assign scl_val = prod >> scl_sh;

  // sine table index and quarter-wave argument
  logic [31:0]      ang;
  logic [SinAw-1:0] sin_idx;
  logic [17:0]      sin_q18;
  logic [16:0]      sin_w;
  logic [30:0]      sin_t;
  assign ang     = sel_q ? phase_q + 32'h4000_0000 : phase_q;
  assign sin_idx = ang[31 -: SinAw];
  assign sin_q18 = 18'(sin_idx) << (18 - SinAw);
  assign sin_w   = sin_q18[16] ? 17'h10000 - {1'b0, sin_q18[15:0]} : {1'b0, sin_q18[15:0]};
  assign sin_t   = {sin_w, 14'd0};

  logic [33:0] sin_rnd;
  logic [18:0] sin_val;
  logic [14:0] sin_mag;
  assign sin_rnd = prod[63:30] + 34'd16384;
  assign sin_val = sin_rnd[33:15];
  assign sin_mag = (sin_val > 19'd32767) ? 15'h7FFF : sin_val[14:0];

  logic [30:0]        v_rnd;
  logic [15:0]        v_mag;
  logic signed [17:0] v_sum;
  assign v_rnd = {1'b0, prod[29:0]} + 31'd16384;
  assign v_mag = v_rnd[30:15];
  assign v_sum = s_neg_q ? 18'(dc_q) - $signed({2'b0, v_mag})
                         : 18'(dc_q) + $signed({2'b0, v_mag});

  logic [63:0] sl_rnd;
  logic [19:0] sl_mag;
  assign sl_rnd = prod + 64'h0000_0800_0000_0000;
  assign sl_mag = sl_rnd[63:44];

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_LIN: begin
        mul_a = {1'b0, lin_span};
        mul_b = dvd_q[31:0];
      end
      ST_LOG_SQ: begin
        mul_a = {1'b0, m_q};
        mul_b = {1'b0, m_q};
      end
      ST_EMAG: begin
        mul_a = dvd_q[31:0];
        mul_b = {11'd0, ex_diff};
      end
      ST_EXP: begin
        mul_a = acc_q;
        mul_b = qf_q[cnt_q[3:0]] ? cssg_pkg::root_q30(4'd15 - cnt_q[3:0]) : cssg_pkg::Q30_ONE;
      end
      ST_SCL: begin
        mul_a = {1'b0, start_q};
        mul_b = acc_q;
      end
      ST_PH: begin
        mul_a = f_q;
        mul_b = {16'd0, step_q};
      end
      ST_SIN_T2: begin
        mul_a = {1'b0, sin_t};
        mul_b = {1'b0, sin_t};
      end
      ST_SIN_H: begin
        mul_a = p_q;
        mul_b = {1'b0, t2s_q};
      end
      ST_SIN_F: begin
        mul_a = p_q;
        mul_b = {1'b0, tt_q};
      end
      ST_VOLT: begin
        mul_a = {17'd0, amp_q};
        mul_b = {17'd0, s_mag_q};
      end
      ST_SL1: begin
        mul_a = {17'd0, amp_q};
        mul_b = {17'd0, c_mag_q};
      end
      ST_SL2: begin
        mul_a = {2'b0, ac_q};
        mul_b = f_q;
      end
      ST_SL3: begin
        mul_a = {2'b0, st2_q};
        mul_b = cssg_pkg::TWO_PI_Q29;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    phase_d = phase_q;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    m_d     = m_q;
    lgr_d   = lgr_q;
    lb_d    = lb_q;
    le_d    = le_q;
    k_d     = k_q;
    qf_d    = qf_q;
    acc_d   = acc_q;
    f_d     = f_q;
    tt_d    = tt_q;
    t2s_d   = t2s_q;
    p_d     = p_q;
    neg_d   = neg_q;
    s_mag_d = s_mag_q;
    s_neg_d = s_neg_q;
    c_mag_d = c_mag_q;
    c_neg_d = c_neg_q;
    volt_d  = volt_q;
    ac_d    = ac_q;
    st2_d   = st2_q;
    slope_d = slope_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          // previous time, clamped at zero
          dvd_d   = {(32'(step_ticks_i) > now_ticks_i) ? 32'd0
                     : now_ticks_i - 32'(step_ticks_i), 32'd0};
          rem_d   = '0;
          step_d  = step_ticks_i;
          cnt_d   = 6'd63;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d = div_ge ? rem_sub[31:0] : rem_sh[31:0];
        dvd_d = {dvd_q[62:0], div_ge};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          if (len_q == 32'd0) dvd_d = '0;
          sel_d   = 1'b0;
          state_d = (mode_q == cssg_pkg::SWEEP_LIN) ? ST_LIN : ST_LOG_NRM;
        end
      end
      ST_LIN: state_d = ST_LIN_W;
      ST_LIN_W: begin
        f_d     = lin_up ? {1'b0, start_q} + prod[63:32] : {1'b0, start_q} - prod[63:32];
        state_d = ST_PH;
      end
      ST_LOG_NRM: begin
        if (lg_x == 31'd0) begin
          // log2 of zero taken as zero
          if (sel_q) begin
            le_d    = '0;
            state_d = ST_EMAG;
          end else begin
            lb_d  = '0;
            sel_d = 1'b1;
          end
        end else begin
          m_d     = 31'(lg_x << (5'd30 - lg_msb));
          lgr_d   = {lg_msb, 16'd0};
          cnt_d   = 6'd15;
          state_d = ST_LOG_SQ;
        end
      end
      ST_LOG_SQ: state_d = ST_LOG_SQ_W;
      ST_LOG_SQ_W: begin
        m_d   = lg_sq[31] ? lg_sq[31:1] : lg_sq[30:0];
        lgr_d = lgr_n;
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          if (sel_q) begin
            le_d    = lgr_n;
            state_d = ST_EMAG;
          end else begin
            lb_d    = lgr_n;
            sel_d   = 1'b1;
            state_d = ST_LOG_NRM;
          end
        end else begin
          state_d = ST_LOG_SQ;
        end
      end
      ST_EMAG: state_d = ST_EMAG_W;
      ST_EMAG_W: begin
        if (!ex_neg) begin
          k_d  = $signed({1'b0, emag[20:16]});
          qf_d = emag[15:0] & ExpMask;
        end else if (emag[15:0] == 16'd0) begin
          k_d  = -$signed({1'b0, emag[20:16]});
          qf_d = '0;
        end else begin
          k_d  = -$signed({1'b0, emag[20:16]}) - 6'sd1;
          qf_d = (16'd0 - emag[15:0]) & ExpMask;
        end
        acc_d   = cssg_pkg::Q30_ONE;
        cnt_d   = 6'd15;
        state_d = ST_EXP;
      end
      ST_EXP: state_d = ST_EXP_W;
      ST_EXP_W: begin
        acc_d   = prod[61:30];
        cnt_d   = cnt_q - 6'd1;
        state_d = (cnt_q == 6'd0) ? ST_SCL : ST_EXP;
      end
      ST_SCL: state_d = ST_SCL_W;
      ST_SCL_W: begin
        f_d     = (scl_val[63:32] != 32'd0) ? 32'hFFFF_FFFF : scl_val[31:0];
        state_d = ST_PH;
      end
      ST_PH: state_d = ST_PH_W;
      ST_PH_W: begin
        phase_d = phase_q + prod[31:0];
        sel_d   = 1'b0;
        state_d = ST_SIN_T2;
      end
      ST_SIN_T2: begin
        tt_d    = sin_t;
        neg_d   = sin_q18[17];
        state_d = ST_SIN_T2_W;
      end
      ST_SIN_T2_W: begin
        t2s_d   = prod[60:30];
        p_d     = cssg_pkg::sin_coef(3'd4);
        cnt_d   = 6'd3;
        state_d = ST_SIN_H;
      end
      ST_SIN_H: state_d = ST_SIN_H_W;
      ST_SIN_H_W: begin
        p_d     = cssg_pkg::sin_coef(cnt_q[2:0]) - prod[61:30];
        cnt_d   = cnt_q - 6'd1;
        state_d = (cnt_q == 6'd0) ? ST_SIN_F : ST_SIN_H;
      end
      ST_SIN_F: state_d = ST_SIN_F_W;
      ST_SIN_F_W: begin
        if (sel_q) begin
          c_mag_d = sin_mag;
          c_neg_d = neg_q;
          state_d = ST_VOLT;
        end else begin
          s_mag_d = sin_mag;
          s_neg_d = neg_q;
          sel_d   = 1'b1;
          state_d = ST_SIN_T2;
        end
      end
      ST_VOLT: state_d = ST_VOLT_W;
      ST_VOLT_W: begin
        if (v_sum > 18'sd32767) begin
          volt_d = 16'sh7FFF;
        end else if (v_sum < -18'sd32768) begin
          volt_d = -16'sh8000;
        end else begin
          volt_d = v_sum[15:0];
        end
        state_d = ST_SL1;
      end
      ST_SL1: state_d = ST_SL1_W;
      ST_SL1_W: begin
        ac_d    = prod[29:0];
        state_d = ST_SL2;
      end
      ST_SL2: state_d = ST_SL2_W;
      ST_SL2_W: begin
        st2_d   = prod[61:32];
        state_d = ST_SL3;
      end
      ST_SL3: state_d = ST_SL3_W;
      ST_SL3_W: begin
        // magnitude stays below 2^18, no clip needed
        slope_d = c_neg_q ? -$signed({12'd0, sl_mag}) : $signed({12'd0, sl_mag});
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
      phase_q <= '0;
      mode_q  <= cssg_pkg::SWEEP_LOG;
      amp_q   <= '0;
      dc_q    <= '0;
      start_q <= cssg_pkg::START_FREQ_RST;
      stop_q  <= cssg_pkg::STOP_FREQ_RST;
      len_q   <= cssg_pkg::SWEEP_LEN_RST;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      phase_q <= phase_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          cssg_pkg::CFG_SWEEP_MODE: mode_q  <= cfg_wdata_i[0];
          cssg_pkg::CFG_AMPLITUDE:  amp_q   <= cfg_wdata_i[14:0];
          cssg_pkg::CFG_DC_OFFSET:  dc_q    <= cfg_wdata_i[15:0];
          cssg_pkg::CFG_START_FREQ: start_q <= cfg_wdata_i[30:0];
          cssg_pkg::CFG_STOP_FREQ:  stop_q  <= cfg_wdata_i[30:0];
          cssg_pkg::CFG_SWEEP_LEN:  len_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    step_q  <= step_d;
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    m_q     <= m_d;
    lgr_q   <= lgr_d;
    lb_q    <= lb_d;
    le_q    <= le_d;
    k_q     <= k_d;
    qf_q    <= qf_d;
    acc_q   <= acc_d;
    f_q     <= f_d;
    tt_q    <= tt_d;
    t2s_q   <= t2s_d;
    p_q     <= p_d;
    neg_q   <= neg_d;
    s_mag_q <= s_mag_d;
    s_neg_q <= s_neg_d;
    c_mag_q <= c_mag_d;
    c_neg_q <= c_neg_d;
    volt_q  <= volt_d;
    ac_q    <= ac_d;
    st2_q   <= st2_d;
    slope_q <= slope_d;
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = (state_q == ST_OUT);
  assign voltage_o       = volt_q;
  assign slope_o         = slope_q;
  assign frequency_now_o = f_q;

`ifndef SYNTH
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result pending");

  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i) |=> !out_valid_o)
    else $error("result word repeated");

  a_lin_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && mode_q == cssg_pkg::SWEEP_LIN && stop_q >= start_q) |->
      (frequency_now_o >= {1'b0, start_q} && frequency_now_o <= {1'b0, stop_q}))
    else $error("linear frequency outside sweep span");

  a_zero_amp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && amp_q == 15'd0) |-> (voltage_o == dc_q && slope_o == 32'sd0))
    else $error("zero amplitude gives nonzero wave");
`endif

endmodule
